### design/lbp_pkg.sv
// lbp_pkg: shared constants and types for the lsb-first bit packer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package lbp_pkg;

    // field and register widths
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int FWIDTH_W   = 6;
    localparam int BYTE_W     = 8;
    localparam int BYTE_SH    = 3;
    localparam int VBITS_W    = 4;
    localparam int CFG_W      = 6;
    localparam int NUM_TYPES  = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_W-1:0] TYPE_WIDTH_RESET = 6'd8;
    localparam int DEF_MAX_FIELD_WIDTH = 32;

    // field kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TYPE_A   = 3'd0,
        KIND_TYPE_B   = 3'd1,
        KIND_TYPE_C   = 3'd2,
        KIND_TYPE_D   = 3'd3,
        KIND_LSB      = 3'd4,
        KIND_MSB      = 3'd5,
        KIND_CHAR7    = 3'd6,
        KIND_FLUSH    = 3'd7
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TYPE_A_WIDTH = 2'd0,
        CFG_TYPE_B_WIDTH = 2'd1,
        CFG_TYPE_C_WIDTH = 2'd2,
        CFG_TYPE_D_WIDTH = 2'd3
    } t_cfg_idx;

    localparam logic [FWIDTH_W-1:0] CHAR7_WIDTH = 6'd7;

endpackage

`default_nettype wire

### design/lbp_in_if.sv
// lbp_in_if: input channel of the bit packer, one field per transaction
// depends on lbp_pkg
`default_nettype none

interface lbp_in_if import lbp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [FWIDTH_W-1:0] field_width;

    modport source (output valid, output kind, output value, output field_width,
                    input ready);
    modport sink   (input valid, input kind, input value, input field_width,
                    output ready);
endinterface

`default_nettype wire

### design/lbp_out_if.sv
// lbp_out_if: output channel of the bit packer, one packed byte per transaction
// depends on lbp_pkg
`default_nettype none

interface lbp_out_if import lbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last;

    modport source (output valid, output out_byte, output valid_bits, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input valid_bits, input last,
                    output ready);
endinterface

`default_nettype wire

### design/lsb_first_bit_packer.sv
// lsb_first_bit_packer: packs variable-width fields lsb first into bytes
// a field is registered on acceptance, then packed into the byte buffer when the
//   buffer is empty or its final byte leaves; the buffer feeds the output channel
// throughput: with the output ready, one field per cycle when it completes at most
//   one byte, else the next field waits until this field's bytes (up to 4) drain;
//   the byte buffer drains one byte a cycle while the output is ready
// reset: synchronous active low; clears pending bits, input valid and buffer count, sets type widths to 8
// depends on lbp_pkg, lbp_in_if, lbp_out_if
`default_nettype none

module lsb_first_bit_packer import lbp_pkg::*; #(
    parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration write port
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    // channels
    lbp_in_if.sink               i_in,
    lbp_out_if.source            o_out
);

    // effective field width limit, never more than the value word
    localparam int EFF_W     = (MAX_FIELD_WIDTH < VALUE_W) ? MAX_FIELD_WIDTH : VALUE_W;
    // pending bits plus one full field
    localparam int STREAM_W  = BYTE_W - 1 + EFF_W;
    localparam int MAX_BYTES = STREAM_W / BYTE_W;
    localparam int BUF_W     = MAX_BYTES * BYTE_W;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = $clog2(STREAM_W + 1);

    // configuration
    logic [CFG_W-1:0]    r_type_w [NUM_TYPES];

    // input register
    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [VALUE_W-1:0]  r_in_value;
    logic [FWIDTH_W-1:0] r_in_fw;

    // packing state
    logic [BYTE_W-1:0]   r_pending;
    logic [BYTE_SH-1:0]  r_pos;

    // byte buffer feeding the output channel
    logic [BUF_W-1:0]    r_buf;
    logic [CNT_W-1:0]    r_cnt;
    logic [VBITS_W-1:0]  r_last_bits;

    // next values from the packing logic
    logic [BUF_W-1:0]    n_buf;
    logic [CNT_W-1:0]    n_cnt;
    logic [VBITS_W-1:0]  n_last_bits;
    logic [BYTE_W-1:0]   n_pending;
    logic [BYTE_SH-1:0]  n_pos;

    logic                in_ready;
    logic                take;
    logic                load;

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    // the buffer reloads when empty or when its final byte leaves this cycle
    assign take     = o_out.valid && o_out.ready;
    assign load     = r_in_valid && ((r_cnt == '0) ||
                                     ((r_cnt == CNT_W'(1)) && take));
    // input register frees up as soon as its field is packed
    assign in_ready = !r_in_valid || load;
    assign i_in.ready = in_ready;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = r_buf[BYTE_W-1:0];
    assign o_out.last       = (r_cnt == CNT_W'(1));
    assign o_out.valid_bits = o_out.last ? r_last_bits : VBITS_W'(BYTE_W);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_type_w[k] <= TYPE_WIDTH_RESET;
            end
        end else if (i_cfg_we) begin
            r_type_w[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_kind  <= i_in.kind;
            r_in_value <= i_in.value;
            r_in_fw    <= i_in.field_width;
        end
    end

    // ------------------------------------------------------------------
    // packing logic: pending bits + field bits form one short stream
    // ------------------------------------------------------------------
    always_comb begin
        logic [FWIDTH_W-1:0] raw_w;
        logic [FWIDTH_W-1:0] w;
        logic                msb_first;
        logic [VALUE_W-1:0]  rev;
        logic [VALUE_W-1:0]  field;
        logic [STREAM_W-1:0] stream;
        logic [TOT_W-1:0]    total;
        logic [CNT_W-1:0]    cnt;

        raw_w     = '0;
        msb_first = 1'b0;
        unique case (t_kind'(r_in_kind)) inside
            KIND_TYPE_A, KIND_TYPE_B, KIND_TYPE_C, KIND_TYPE_D: begin
                raw_w = r_type_w[r_in_kind[CFG_IDX_W-1:0]];
            end
            KIND_LSB: begin
                raw_w = r_in_fw;
            end
            KIND_MSB: begin
                raw_w     = r_in_fw;
                msb_first = 1'b1;
            end
            KIND_CHAR7: begin
                raw_w = CHAR7_WIDTH;
            end
            KIND_FLUSH: begin
                raw_w = '0;
            end
        endcase

        // saturate oversized widths
        w = (raw_w > FWIDTH_W'(EFF_W)) ? FWIDTH_W'(EFF_W) : raw_w;

        // msb first: reverse the word, then bring the low w bits down
        for (int k = 0; k < VALUE_W; k++) begin
            rev[k] = r_in_value[VALUE_W-1-k];
        end
        if (msb_first) begin
            field = rev >> (FWIDTH_W'(VALUE_W) - w);
        end else begin
            // shift of all ones by the full word width leaves an all-ones mask
            field = r_in_value & ~({VALUE_W{1'b1}} << w);
        end
        if (w == '0) begin
            field = '0;
        end

        stream = STREAM_W'(r_pending) | (STREAM_W'(field) << r_pos);
        total  = TOT_W'(r_pos) + TOT_W'(w);
        cnt    = CNT_W'(total >> BYTE_SH);

        if (t_kind'(r_in_kind) == KIND_FLUSH) begin
            // partial byte goes out alone, tagged with its bit count
            n_buf       = BUF_W'(r_pending);
            n_cnt       = (r_pos != '0) ? CNT_W'(1) : '0;
            n_last_bits = VBITS_W'(r_pos);
            n_pending   = '0;
            n_pos       = '0;
        end else begin
            n_buf       = stream[BUF_W-1:0];
            n_cnt       = cnt;
            n_last_bits = VBITS_W'(BYTE_W);
            n_pending   = BYTE_W'(stream >> {cnt, {BYTE_SH{1'b0}}});
            n_pos       = total[BYTE_SH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // packing state and byte buffer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pos     <= '0;
            r_pending <= '0;
        end else if (load) begin
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_pending <= n_pending;
        end else if (take) begin
            r_cnt     <= r_cnt - CNT_W'(1);
        end
    end

    // buffer payload, shifted down one byte per output transaction
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf       <= n_buf;
            r_last_bits <= n_last_bits;
        end else if (take) begin
            r_buf       <= r_buf >> BYTE_W;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // buffer never holds more bytes than one field can complete
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("byte buffer count out of range");

    // a flush always leaves an empty partial byte
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (t_kind'(r_in_kind) == KIND_FLUSH)) |=>
            ((r_pos == '0) && (r_pending == '0)))
        else $error("flush left pending bits");

    // only the final byte of a field may carry a partial bit count
    a_full_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.valid_bits == VBITS_W'(BYTE_W)))
        else $error("partial byte before end of field");

    // an empty buffer never stalls the input side
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> in_ready)
        else $error("input stalled with empty buffer");

endmodule

`default_nettype wire
